// File: sv/pvaa_pkg.sv
// Shared types and constants of the polyphonic voice allocator.
// Holds the command, job and result structs, the phase and kind codes and the
// envelope step function. No dependencies.
package pvaa_pkg;

    localparam int NOTE_W      = 7;
    localparam int VOICE_W     = 4;
    localparam int CNT_W       = 4;
    localparam int LEVEL_W     = 16;
    localparam int CFG_W       = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [LEVEL_W-1:0] ONE_Q15 = 16'd32768;

    // Register reset values.
    localparam logic [CFG_W-1:0] ATTACK_RESET  = 16'd328;
    localparam logic [CFG_W-1:0] DECAY_RESET   = 16'd164;
    localparam logic [CFG_W-1:0] SUSTAIN_RESET = 16'd16384;
    localparam logic [CFG_W-1:0] RELEASE_RESET = 16'd164;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_ON   = 2'd1,
        FUNC_OFF  = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_ON   = 2'd1,
        KIND_OFF  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_DORMANT = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } cfg_reg_t;

    // Classified work handed from the front end to the engine.
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_NOTE_ON  = 3'd1,
        OP_NOTE_OFF = 3'd2,
        OP_BAD_ON   = 3'd3,
        OP_BAD_OFF  = 3'd4
    } job_op_t;

    typedef struct packed {
        func_t             func;
        logic [NOTE_W-1:0] note;
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic [VOICE_W-1:0] voice;
        logic               granted;
        logic               stolen;
        logic [LEVEL_W-1:0] level;
        phase_t             phase;
        logic               voice_on;
        logic [CNT_W-1:0]   active_count;
        logic               last;
    } result_t;

    typedef struct packed {
        job_op_t           op;
        logic [NOTE_W-1:0] note;
    } job_t;

    typedef struct packed {
        logic [CFG_W-1:0] attack_step;
        logic [CFG_W-1:0] decay_step;
        logic [CFG_W-1:0] sustain_level;
        logic [CFG_W-1:0] release_step;
    } cfg_t;

    // State of one voice envelope.
    typedef struct packed {
        logic               on;
        phase_t             phase;
        logic [LEVEL_W-1:0] level;
    } env_t;

    // Clamp a register value to 1.0 in Q1.15.
    function automatic logic [LEVEL_W-1:0] sat_q15(input logic [CFG_W-1:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    // One envelope step of an active voice; steps are already clamped.
    function automatic env_t env_step(
        input env_t               e,
        input logic [LEVEL_W-1:0] atk,
        input logic [LEVEL_W-1:0] dec,
        input logic [LEVEL_W-1:0] sus,
        input logic [LEVEL_W-1:0] rel
    );
        env_t               r;
        logic [LEVEL_W:0]   sum;
        logic [LEVEL_W-1:0] gap;
        r   = e;
        sum = '0;
        gap = '0;
        case (e.phase)
            PH_ATTACK: begin
                if (e.level < ONE_Q15) begin
                    sum = {1'b0, e.level} + {1'b0, atk};
                    if (sum >= {1'b0, ONE_Q15}) begin
                        r.level = ONE_Q15;
                        r.phase = PH_DECAY;
                    end else begin
                        r.level = sum[LEVEL_W-1:0];
                    end
                end
            end
            PH_DECAY: begin
                if (e.level > sus) begin
                    gap = e.level - sus;
                    if (gap <= dec) begin
                        r.level = sus;
                        r.phase = PH_SUSTAIN;
                    end else begin
                        r.level = e.level - dec;
                    end
                end else if (e.level < sus) begin
                    gap = sus - e.level;
                    if (gap <= dec) begin
                        r.level = sus;
                        r.phase = PH_SUSTAIN;
                    end else begin
                        r.level = e.level + dec;
                    end
                end else begin
                    r.phase = PH_SUSTAIN;
                end
            end
            PH_RELEASE: begin
                if (e.level <= rel) begin
                    r.level = '0;
                    r.phase = PH_DORMANT;
                    r.on    = 1'b0;
                end else begin
                    r.level = e.level - rel;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

endpackage

// File: sv/pvaa_front.sv
// Front end: takes commands, drops unused codes, range-checks the note and
// holds one classified job until the queue takes it. Depends on pvaa_pkg.
module pvaa_front
    import pvaa_pkg::*;
#(
    parameter int NOTES = 128
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic push,
    output job_t push_job,
    input  logic q_full
);

    job_t job_reg, job_next;
    logic job_vld_reg, job_vld_next;
    job_t new_job;
    logic keep;
    logic accept;
    logic note_ok;

    // Classify the incoming command.
    always_comb
    begin
        note_ok      = int'(cmd.note) < NOTES;
        new_job.note = cmd.note;
        new_job.op   = OP_TICK;
        keep         = 1'b1;
        case (cmd.func)
            FUNC_TICK: new_job.op = OP_TICK;
            FUNC_ON:   new_job.op = note_ok ? OP_NOTE_ON : OP_BAD_ON;
            FUNC_OFF:  new_job.op = note_ok ? OP_NOTE_OFF : OP_BAD_OFF;
            default:   keep = 1'b0;
        endcase
    end

    // The holding register frees up as soon as the queue has room.
    assign push     = job_vld_reg && !q_full;
    assign push_job = job_reg;
    assign busy     = job_vld_reg && q_full;
    assign accept   = start && !busy;

    always_comb
    begin
        job_next     = accept ? new_job : job_reg;
        job_vld_next = accept ? keep : (push ? 1'b0 : job_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            job_vld_reg <= 1'b0;
        end else begin
            job_vld_reg <= job_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

// File: sv/pvaa_queue.sv
// Short job queue between the front end and the engine.
// Depends on pvaa_pkg for the job type and the queue depth.
module pvaa_queue
    import pvaa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = cnt_reg == '0;
    assign pop_job = q_mem[rd_ptr_reg];

    // Pointer and fill-count update; depth is a power of two so pointers wrap.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: sv/pvaa_engine.sv
// Engine: runs one job at a time against the voice table, stepping one voice
// per cycle through a shared envelope unit. Depends on pvaa_pkg.
module pvaa_engine
    import pvaa_pkg::*;
#(
    parameter int VOICES = 12,
    parameter int NOTES  = 128
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_empty,
    input  job_t    q_job,
    output logic    pop,
    output logic    strobe,
    output result_t result
);

    localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NTAG_W = (NOTES > 1) ? $clog2(NOTES) : 1;
    localparam logic [VOICE_W-1:0] VOICE_NONE = VOICE_W'(VOICES);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(VOICES - 1);

    typedef enum logic [2:0] {
        B_IDLE,
        B_TICK_PREP,
        B_TICK_STEP,
        B_ON_FREE,
        B_ON_SCAN,
        B_ON_GRANT,
        B_OFF_FIND,
        B_OFF_DO
    } b_state_t;

    b_state_t          state_reg, state_next;
    logic [NOTE_W-1:0] note_reg, note_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic              found_reg, found_next;
    logic              steal_reg, steal_next;
    logic [LEVEL_W:0]  best_reg, best_next;
    logic [CNT_W-1:0]  tcnt_reg, tcnt_next;
    result_t           res_reg, res_next;
    logic              strobe_reg, strobe_next;

    // Voice table.
    logic [VOICES-1:0]  act_reg;
    phase_t             ph_reg  [VOICES];
    logic [LEVEL_W-1:0] lvl_reg [VOICES];
    logic [VOICES-1:0]  own_vld_reg;
    logic [NTAG_W-1:0]  own_reg [VOICES];

    logic               vw_en;
    logic [IDX_W-1:0]   vw_idx;
    env_t               vw_env;
    logic [VOICES-1:0]  own_clr;
    logic [VOICES-1:0]  own_set;
    logic               own_set_en;

    logic [LEVEL_W-1:0] atk_s, dec_s, sus_s, rel_s;
    env_t               cur_env;
    env_t               stepped;
    logic [CNT_W-1:0]   act_cnt;
    logic [VOICES-1:0]  ends;
    logic [VOICES-1:0]  match;
    logic [VOICES-1:0]  hit;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   hit_idx;
    logic [NTAG_W-1:0]  tag;

    function automatic logic [CNT_W-1:0] count_on(input logic [VOICES-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < VOICES; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

    assign atk_s = sat_q15(cfg.attack_step);
    assign dec_s = sat_q15(cfg.decay_step);
    assign sus_s = sat_q15(cfg.sustain_level);
    assign rel_s = sat_q15(cfg.release_step);
    assign tag   = note_reg[NTAG_W-1:0];

    // The voice under the scan index and its stepped value.
    always_comb
    begin
        cur_env.on    = act_reg[idx_reg];
        cur_env.phase = ph_reg[idx_reg];
        cur_env.level = lvl_reg[idx_reg];
        stepped       = cur_env.on ? env_step(cur_env, atk_s, dec_s, sus_s, rel_s)
                                   : cur_env;
    end

    // Per-voice flags: releases that end this tick, owner tag matches.
    always_comb
    begin
        for (int i = 0; i < VOICES; i++) begin
            ends[i]  = act_reg[i] && (ph_reg[i] == PH_RELEASE) && (lvl_reg[i] <= rel_s);
            match[i] = own_vld_reg[i] && (own_reg[i] == tag);
        end
        hit     = match & act_reg;
        act_cnt = count_on(act_reg);
    end

    // Lowest-numbered free voice and the voice holding the note.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        hit_idx    = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!act_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (hit[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Job sequencer.
    always_comb
    begin
        state_next  = state_reg;
        note_next   = note_reg;
        idx_next    = idx_reg;
        pick_next   = pick_reg;
        found_next  = found_reg;
        steal_next  = steal_reg;
        best_next   = best_reg;
        tcnt_next   = tcnt_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        pop         = 1'b0;
        vw_en       = 1'b0;
        vw_idx      = idx_reg;
        vw_env      = stepped;
        own_clr     = '0;
        own_set     = '0;
        own_set_en  = 1'b0;

        // Refused answers share one shape; fields are overridden below.
        res_next.voice        = VOICE_NONE;
        res_next.granted      = 1'b0;
        res_next.stolen       = 1'b0;
        res_next.level        = '0;
        res_next.phase        = PH_DORMANT;
        res_next.voice_on     = 1'b0;
        res_next.active_count = act_cnt;
        res_next.last         = 1'b1;

        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    pop       = 1'b1;
                    note_next = q_job.note;
                    case (q_job.op)
                        OP_TICK:     state_next = B_TICK_PREP;
                        OP_NOTE_ON:  state_next = B_ON_FREE;
                        OP_NOTE_OFF: state_next = B_OFF_FIND;
                        OP_BAD_ON: begin
                            res_next.kind = KIND_ON;
                            strobe_next   = 1'b1;
                        end
                        OP_BAD_OFF: begin
                            res_next.kind = KIND_OFF;
                            strobe_next   = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Every tick report carries the count after the whole tick.
            B_TICK_PREP: begin
                tcnt_next  = count_on(act_reg & ~ends);
                idx_next   = '0;
                state_next = B_TICK_STEP;
            end

            B_TICK_STEP: begin
                vw_en                 = 1'b1;
                res_next.kind         = KIND_TICK;
                res_next.voice        = VOICE_W'(idx_reg);
                res_next.level        = stepped.level;
                res_next.phase        = stepped.phase;
                res_next.voice_on     = stepped.on;
                res_next.active_count = tcnt_reg;
                res_next.last         = idx_reg == LAST_IDX;
                strobe_next           = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = B_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            B_ON_FREE: begin
                if (free_found) begin
                    pick_next  = free_idx;
                    found_next = 1'b1;
                    steal_next = 1'b0;
                    state_next = B_ON_GRANT;
                end else begin
                    idx_next   = '0;
                    best_next  = {1'b0, ONE_Q15} + 1'b1;
                    found_next = 1'b0;
                    steal_next = 1'b1;
                    state_next = B_ON_SCAN;
                end
            end

            // Quietest voice not in attack, lowest index on ties.
            B_ON_SCAN: begin
                if ((cur_env.phase != PH_ATTACK) && ({1'b0, cur_env.level} < best_reg)) begin
                    best_next  = {1'b0, cur_env.level};
                    pick_next  = idx_reg;
                    found_next = 1'b1;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = B_ON_GRANT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            B_ON_GRANT: begin
                res_next.kind = KIND_ON;
                if (found_reg) begin
                    vw_en                 = 1'b1;
                    vw_idx                = pick_reg;
                    vw_env.on             = 1'b1;
                    vw_env.phase          = PH_ATTACK;
                    vw_env.level          = '0;
                    own_clr               = match;
                    own_set[pick_reg]     = 1'b1;
                    own_set_en            = 1'b1;
                    res_next.voice        = VOICE_W'(pick_reg);
                    res_next.granted      = 1'b1;
                    res_next.stolen       = steal_reg;
                    res_next.phase        = PH_ATTACK;
                    res_next.voice_on     = 1'b1;
                    res_next.active_count = act_cnt + CNT_W'(!steal_reg);
                end
                strobe_next = 1'b1;
                state_next  = B_IDLE;
            end

            B_OFF_FIND: begin
                if (|hit) begin
                    idx_next   = hit_idx;
                    state_next = B_OFF_DO;
                end else begin
                    res_next.kind = KIND_OFF;
                    strobe_next   = 1'b1;
                    state_next    = B_IDLE;
                end
            end

            B_OFF_DO: begin
                vw_en             = 1'b1;
                vw_env            = cur_env;
                vw_env.phase      = PH_RELEASE;
                own_clr[idx_reg]  = 1'b1;
                res_next.kind     = KIND_OFF;
                res_next.voice    = VOICE_W'(idx_reg);
                res_next.granted  = 1'b1;
                res_next.level    = cur_env.level;
                res_next.phase    = PH_RELEASE;
                res_next.voice_on = 1'b1;
                strobe_next       = 1'b1;
                state_next        = B_IDLE;
            end

            default: state_next = B_IDLE;
        endcase
    end

    // Sequencer state and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= B_IDLE;
            note_reg   <= '0;
            idx_reg    <= '0;
            pick_reg   <= '0;
            found_reg  <= 1'b0;
            steal_reg  <= 1'b0;
            best_reg   <= '0;
            tcnt_reg   <= '0;
            res_reg    <= '0;
            strobe_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            note_reg   <= note_next;
            idx_reg    <= idx_next;
            pick_reg   <= pick_next;
            found_reg  <= found_next;
            steal_reg  <= steal_next;
            best_reg   <= best_next;
            tcnt_reg   <= tcnt_next;
            res_reg    <= res_next;
            strobe_reg <= strobe_next;
        end
    end

    // Voice table write port and owner flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            act_reg     <= '0;
            own_vld_reg <= '0;
            for (int i = 0; i < VOICES; i++) begin
                ph_reg[i]  <= PH_DORMANT;
                lvl_reg[i] <= '0;
            end
        end else begin
            if (vw_en) begin
                act_reg[vw_idx] <= vw_env.on;
                ph_reg[vw_idx]  <= vw_env.phase;
                lvl_reg[vw_idx] <= vw_env.level;
            end
            own_vld_reg <= (own_vld_reg & ~own_clr) | own_set;
        end
    end

    // Note held by each voice; meaningful only while its owner flag is set.
    always_ff @(posedge clk)
    begin
        if (own_set_en) begin
            own_reg[pick_reg] <= tag;
        end
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

// File: sv/polyphonic_voice_allocator_adsr_top.sv
// With the engine idle, a request passes the front-end holding register and the job queue, and
// the engine answers from its result register; an out-of-range note is refused without a scan.
// The engine runs one job at a time: a tick uses one shared envelope unit, one voice a cycle,
// with reports back to back; a note on that steals a voice first scans the levels serially.
// Up to three requests wait; results cannot be stalled.
// Reset is asynchronous; all voices come up dormant with no clearing pass.
module polyphonic_voice_allocator_adsr_top
    import pvaa_pkg::*;
#(
    parameter int VOICES = 12,
    parameter int NOTES  = 128
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             strobe,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t pop_job;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_ATTACK:  cfg_next.attack_step   = cfg_data;
                REG_DECAY:   cfg_next.decay_step    = cfg_data;
                REG_SUSTAIN: cfg_next.sustain_level = cfg_data;
                REG_RELEASE: cfg_next.release_step  = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.attack_step   <= ATTACK_RESET;
            cfg_reg.decay_step    <= DECAY_RESET;
            cfg_reg.sustain_level <= SUSTAIN_RESET;
            cfg_reg.release_step  <= RELEASE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pvaa_front #(
        .NOTES (NOTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    pvaa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    pvaa_engine #(
        .VOICES (VOICES),
        .NOTES  (NOTES)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_job   (pop_job),
        .pop     (pop),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

// File: sv/pvaa_checker.sv
// Port-level checks on the result stream of the voice allocator, bound to the
// top level. Depends on pvaa_pkg and polyphonic_voice_allocator_adsr_top.
module pvaa_checker
    import pvaa_pkg::*;
#(
    parameter int VOICES = 12
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    strobe,
    input result_t result
);

    // Tick reports name a real voice and only the highest one closes the tick.
    a_tick_voice: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_TICK) |->
            (result.voice < VOICE_W'(VOICES)) &&
            (result.last == (result.voice == VOICE_W'(VOICES - 1))))
        else $error("tick report voice or last flag wrong");

    // Tick reports come back to back in voice order with one count.
    a_tick_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_TICK) && !result.last |=>
            strobe && (result.kind == KIND_TICK) &&
            (result.voice == $past(result.voice) + 1'b1) &&
            (result.active_count == $past(result.active_count)))
        else $error("tick report run broken");

    // A note answer is a single result.
    a_note_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind != KIND_TICK) |-> result.last)
        else $error("note answer not marked last");

    // A refused note answer names no voice and carries no envelope.
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind != KIND_TICK) && !result.granted |->
            (result.voice == VOICE_W'(VOICES)) && (result.level == '0) &&
            !result.voice_on && !result.stolen)
        else $error("refused answer malformed");

    // Levels stay within 1.0 and the count within the voice pool.
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.level <= ONE_Q15) &&
            (result.active_count <= CNT_W'(VOICES)))
        else $error("level or active count out of range");

endmodule

bind polyphonic_voice_allocator_adsr_top pvaa_checker #(
    .VOICES (VOICES)
) u_pvaa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .result (result)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for polyphonic_voice_allocator_adsr_top: voice allocation,
// stealing and the per-voice ADSR steps are predicted and compared result by result.
// Depends on pvaa_pkg and the top-level RTL only.
module tb_top;
    import pvaa_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 25;

    // Predicts the allocator and envelopes, and holds the reports still owed.
    class voice_scoreboard;
        localparam int N_VOICES = 12;
        localparam int N_NOTES  = 128;
        localparam bit [3:0] NO_VOICE = 4'd12;

        bit [15:0] atk_step;
        bit [15:0] dec_step;
        bit [15:0] sus_lvl;
        bit [15:0] rel_step;
        bit        on_flag       [N_VOICES];
        phase_t    env_ph        [N_VOICES];
        bit [15:0] env_lv        [N_VOICES];
        bit [3:0]  voice_of_note [N_NOTES];
        result_t   owed_reports  [$];
        int        errors;
        int        seen;

        function new();
            atk_step = ATTACK_RESET;
            dec_step = DECAY_RESET;
            sus_lvl  = SUSTAIN_RESET;
            rel_step = RELEASE_RESET;
            for (int v = 0; v < N_VOICES; v++)
            begin
                on_flag[v] = 1'b0;
                env_ph[v]  = PH_DORMANT;
                env_lv[v]  = '0;
            end
            for (int n = 0; n < N_NOTES; n++)
                voice_of_note[n] = NO_VOICE;
            errors = 0;
            seen   = 0;
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction

        function void set_reg(cfg_reg_t idx, bit [15:0] val);
            case (idx)
                REG_ATTACK:  atk_step = val;
                REG_DECAY:   dec_step = val;
                REG_SUSTAIN: sus_lvl  = val;
                default:     rel_step = val;
            endcase
        endfunction

        // Register values above 1.0 act as 1.0.
        function int clamp_one(bit [15:0] v);
            return (v > ONE_Q15) ? int'(ONE_Q15) : int'(v);
        endfunction

        function bit [3:0] count_on();
            int n;
            n = 0;
            for (int v = 0; v < N_VOICES; v++)
                if (on_flag[v])
                    n++;
            return 4'(n);
        endfunction

        // One envelope step of an active voice.
        function void advance_envelope(int v);
            int lv;
            int s;
            int d;
            lv = int'(env_lv[v]);
            s  = clamp_one(sus_lvl);
            case (env_ph[v])
                PH_ATTACK:
                begin
                    if (lv < int'(ONE_Q15))
                    begin
                        lv += clamp_one(atk_step);
                        if (lv >= int'(ONE_Q15))
                        begin
                            lv = int'(ONE_Q15);
                            env_ph[v] = PH_DECAY;
                        end
                    end
                end
                PH_DECAY:
                begin
                    d = clamp_one(dec_step);
                    if (lv > s)
                    begin
                        if (lv - s <= d)
                        begin
                            lv = s;
                            env_ph[v] = PH_SUSTAIN;
                        end
                        else
                            lv -= d;
                    end
                    else if (lv < s)
                    begin
                        if (s - lv <= d)
                        begin
                            lv = s;
                            env_ph[v] = PH_SUSTAIN;
                        end
                        else
                            lv += d;
                    end
                    else
                        env_ph[v] = PH_SUSTAIN;
                end
                PH_RELEASE:
                begin
                    d = clamp_one(rel_step);
                    if (lv <= d)
                    begin
                        lv = 0;
                        env_ph[v] = PH_DORMANT;
                        on_flag[v] = 1'b0;
                    end
                    else
                        lv -= d;
                end
                default:
                begin
                end
            endcase
            env_lv[v] = lv[15:0];
        endfunction

        // Single answer to a note on or note off; the count is taken afterwards.
        function void push_answer(kind_t k, bit [3:0] v, bit g, bit s, bit [15:0] lv,
                                  phase_t ph, bit on);
            result_t r;
            r.kind         = k;
            r.voice        = v;
            r.granted      = g;
            r.stolen       = s;
            r.level        = lv;
            r.phase        = ph;
            r.voice_on     = on;
            r.active_count = count_on();
            r.last         = 1'b1;
            owed_reports.push_back(r);
        endfunction

        // Update the state for an accepted request and queue its reports.
        function void apply_request(cmd_t c);
            result_t   r;
            bit [3:0]  cnt;
            int        pick;
            int        best;
            int        v;
            bit        took_busy;
            pick      = -1;
            took_busy = 1'b0;
            case (c.func)
                FUNC_TICK:
                begin
                    for (int i = 0; i < N_VOICES; i++)
                        if (on_flag[i])
                            advance_envelope(i);
                    cnt = count_on();
                    for (int i = 0; i < N_VOICES; i++)
                    begin
                        r.kind         = KIND_TICK;
                        r.voice        = 4'(i);
                        r.granted      = 1'b0;
                        r.stolen       = 1'b0;
                        r.level        = env_lv[i];
                        r.phase        = env_ph[i];
                        r.voice_on     = on_flag[i];
                        r.active_count = cnt;
                        r.last         = (i == N_VOICES - 1);
                        owed_reports.push_back(r);
                    end
                end
                FUNC_ON:
                begin
                    for (int i = 0; i < N_VOICES; i++)
                        if (!on_flag[i] && pick < 0)
                            pick = i;
                    // All busy: steal the quietest voice that is past its attack.
                    if (pick < 0)
                    begin
                        best = int'(ONE_Q15) + 1;
                        for (int i = 0; i < N_VOICES; i++)
                            if (env_ph[i] != PH_ATTACK && int'(env_lv[i]) < best)
                            begin
                                best = int'(env_lv[i]);
                                pick = i;
                            end
                        if (pick >= 0)
                        begin
                            took_busy = 1'b1;
                            for (int n = 0; n < N_NOTES; n++)
                                if (int'(voice_of_note[n]) == pick)
                                    voice_of_note[n] = NO_VOICE;
                        end
                    end
                    if (pick < 0)
                        push_answer(KIND_ON, NO_VOICE, 1'b0, 1'b0, '0, PH_DORMANT, 1'b0);
                    else
                    begin
                        voice_of_note[c.note] = 4'(pick);
                        on_flag[pick] = 1'b1;
                        env_ph[pick]  = PH_ATTACK;
                        env_lv[pick]  = '0;
                        push_answer(KIND_ON, 4'(pick), 1'b1, took_busy, '0, PH_ATTACK, 1'b1);
                    end
                end
                FUNC_OFF:
                begin
                    v = int'(voice_of_note[c.note]);
                    if (v < N_VOICES && on_flag[v])
                    begin
                        env_ph[v] = PH_RELEASE;
                        voice_of_note[c.note] = NO_VOICE;
                        push_answer(KIND_OFF, 4'(v), 1'b1, 1'b0, env_lv[v], PH_RELEASE, 1'b1);
                    end
                    else
                        push_answer(KIND_OFF, NO_VOICE, 1'b0, 1'b0, '0, PH_DORMANT, 1'b0);
                end
                default:
                begin
                end
            endcase
        endfunction

        task flag_mismatch(string msg);
            errors++;
            $display("mismatch at result %0d: %s", seen, msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            seen++;
            if (owed_reports.size() == 0)
                flag_mismatch("result with none outstanding");
            else
            begin
                want = owed_reports.pop_front();
                compare_field("kind", 16'(got.kind), 16'(want.kind));
                compare_field("voice", 16'(got.voice), 16'(want.voice));
                compare_field("granted", 16'(got.granted), 16'(want.granted));
                compare_field("stolen", 16'(got.stolen), 16'(want.stolen));
                compare_field("level", got.level, want.level);
                compare_field("phase", 16'(got.phase), 16'(want.phase));
                compare_field("voice_on", 16'(got.voice_on), 16'(want.voice_on));
                compare_field("active_count", 16'(got.active_count), 16'(want.active_count));
                compare_field("last", 16'(got.last), 16'(want.last));
            end
        endtask
    endclass

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    cmd_t             cmd       = '0;
    logic             strobe;
    result_t          result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    cfg_reg_t         cfg_index = REG_ATTACK;
    logic [CFG_W-1:0] cfg_data  = '0;

    voice_scoreboard sb;
    int              sender_idle_pct = 0;
    int              cycle_count     = 0;

    polyphonic_voice_allocator_adsr_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Results cannot be held off, so every strobe is checked as it comes.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(result);
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one request, with random idle cycles ahead of it, and wait for acceptance.
    task send_request(func_t f, logic [NOTE_W-1:0] n);
        cmd_t c;
        c.func = f;
        c.note = n;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.apply_request(c);
    endtask

    // Stop sending, wait for every owed report, then wait out the drain period.
    task settle_block();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four envelope registers back to back; valid stays high between writes.
    task program_envelope(bit [15:0] atk, bit [15:0] dec, bit [15:0] sus, bit [15:0] rel);
        bit [15:0] vals [4];
        vals[0] = atk;
        vals[1] = dec;
        vals[2] = sus;
        vals[3] = rel;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_reg(cfg_reg_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly notes from a narrow band so that note offs find their voices.
    task random_request(output bit counted);
        int                r;
        logic [NOTE_W-1:0] n;
        r = $urandom_range(99);
        if ($urandom_range(99) < 65)
            n = 7'd48 + 7'($urandom_range(11));
        else
            n = 7'($urandom);
        counted = 1'b1;
        if (r < 35)
            send_request(FUNC_TICK, n);
        else if (r < 70)
            send_request(FUNC_ON, n);
        else if (r < 95)
            send_request(FUNC_OFF, n);
        else
        begin
            send_request(FUNC_NONE, n);
            counted = 1'b0;
        end
    endtask

    initial
    begin
        int sent;
        bit counted;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tick, unmapped off, unused func, note extremes, repeated on.
        send_request(FUNC_TICK, 7'd0);
        send_request(FUNC_OFF, 7'd5);
        send_request(FUNC_NONE, 7'd127);
        send_request(FUNC_ON, 7'd0);
        send_request(FUNC_ON, 7'd127);
        send_request(FUNC_ON, 7'd127);
        send_request(FUNC_OFF, 7'd127);
        send_request(FUNC_OFF, 7'd127);
        send_request(FUNC_OFF, 7'd0);
        send_request(FUNC_TICK, 7'd127);
        settle_block();

        // Zero attack: fill every voice, then a note on finds all in attack and is dropped.
        program_envelope(16'd0, 16'd164, 16'd16384, 16'd32768);
        for (int i = 0; i < 11; i++)
            send_request(FUNC_ON, 7'(10 + i));
        send_request(FUNC_ON, 7'd21);
        send_request(FUNC_TICK, 7'd0);
        settle_block();

        // Full attack: all voices reach decay, a note on steals voice 0 and unmaps note 10.
        program_envelope(16'd32768, 16'd164, 16'd16384, 16'd164);
        send_request(FUNC_TICK, 7'd0);
        send_request(FUNC_ON, 7'd40);
        send_request(FUNC_OFF, 7'd10);
        settle_block();

        // Random phases: idle 11 percent, then 53, then none; new settings each phase.
        for (int ph = 0; ph < 6; ph++)
        begin
            sender_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 53 : 0;
            case (ph)
                1: program_envelope(16'd32768, 16'd32768, 16'd0, 16'd32768);
                2: program_envelope(16'hFFFF, 16'd0, 16'd32768, 16'd0);
                3: program_envelope(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                5: program_envelope(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom));
                default: program_envelope(16'($urandom_range(4000, 12000)),
                                          16'($urandom_range(1000, 6000)),
                                          16'($urandom_range(0, 32768)),
                                          16'($urandom_range(1000, 6000)));
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS)
            begin
                random_request(counted);
                if (counted)
                    sent++;
            end
            settle_block();
        end

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: polyphonic_voice_allocator_adsr_top.f
sv/pvaa_pkg.sv
sv/pvaa_front.sv
sv/pvaa_queue.sv
sv/pvaa_engine.sv
sv/polyphonic_voice_allocator_adsr_top.sv
sv/pvaa_checker.sv
tb/sv/tb_top.sv
